>>> design/nsvl_pkg.sv
package nsvl_pkg;

	// Field widths
	localparam int COORD_W = 20;
	localparam int TAG_W   = 4;
	localparam int CNT_W   = 7;
	localparam int IDX_W   = 6;

	// Datapath widths: coordinate difference, squared distance, root, edge
	localparam int DIFF_W  = COORD_W + 1;
	localparam int DIST_W  = 2 * DIFF_W - 1;
	localparam int ROOT_W  = (DIST_W + 1) / 2;
	localparam int RAD_W   = 2 * ROOT_W;
	localparam int REM_W   = ROOT_W + 2;
	localparam int STEP_W  = $clog2(ROOT_W + 1);
	localparam int EDGE_W  = 21;
	localparam logic [EDGE_W-1:0] EDGE_MAX = {EDGE_W{1'b1}};

	// Input item modes
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic query_start;
		logic site_write;
		logic scan_issue;
		logic root_start;
		logic out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic scan_more;
		logic pipe_idle;
		logic root_busy;
		logic out_free;
	} dp_stat_t;

endpackage

>>> design/nsvl_sqrt.sv
module nsvl_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [nsvl_pkg::DIST_W-1:0]   radicand,
	output logic                          busy,
	output logic [nsvl_pkg::ROOT_W-1:0]   root
);
	import nsvl_pkg::*;

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;

	logic [REM_W+1:0]  trial_rem;
	logic [REM_W+1:0]  trial_sub;
	logic              fits;

	// One root bit per cycle: bring down two radicand bits, try subtracting 4r+1
	always_comb begin
		trial_rem = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial_sub = {2'b00, root_q, 2'b01};
		fits      = (trial_rem >= trial_sub);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(ROOT_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Hold radicand, partial remainder and root
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= RAD_W'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			root_q <= {root_q[ROOT_W-2:0], fits};
			if (fits) begin
				rem_q <= REM_W'(trial_rem - trial_sub);
			end else begin
				rem_q <= REM_W'(trial_rem);
			end
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

>>> design/nsvl_ctrl.sv
module nsvl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                mode,
	output logic                item_stall,
	input  nsvl_pkg::dp_stat_t  stat,
	output nsvl_pkg::dp_cmd_t   cmd
);
	import nsvl_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_ROOT  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Issue site writes from idle; sequence a query: scan, drain the distance pipe, take roots, deliver
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (mode == MODE_QUERY) begin
						cmd.query_start = 1'b1;
						state_d         = ST_SCAN;
					end else begin
						cmd.site_write = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (!stat.scan_more) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (stat.pipe_idle) begin
					cmd.root_start = 1'b1;
					state_d        = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (!stat.root_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_stall = (state_q != ST_IDLE);

endmodule

>>> design/nsvl_datapath.sv
module nsvl_datapath #(
	parameter int MAX_SITES = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  nsvl_pkg::dp_cmd_t                   cmd,
	output nsvl_pkg::dp_stat_t                  stat,
	input  logic                                site_count_we,
	input  logic [nsvl_pkg::CNT_W-1:0]          site_count_wdata,
	input  logic [nsvl_pkg::IDX_W-1:0]          site_index,
	input  logic signed [nsvl_pkg::COORD_W-1:0] point_x,
	input  logic signed [nsvl_pkg::COORD_W-1:0] point_y,
	input  logic [nsvl_pkg::TAG_W-1:0]          site_class,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [nsvl_pkg::TAG_W-1:0]          nearest_class,
	output logic signed [nsvl_pkg::COORD_W-1:0] nearest_x,
	output logic signed [nsvl_pkg::COORD_W-1:0] nearest_y,
	output logic [nsvl_pkg::EDGE_W-1:0]         edge_distance
);
	import nsvl_pkg::*;

	localparam int AW    = $clog2(MAX_SITES);
	localparam int CW    = AW + 1;
	localparam int WORD_W = TAG_W + 2 * COORD_W;

	// Site table: {tag, y, x}
	logic [WORD_W-1:0] site_mem [MAX_SITES];

	logic [CNT_W-1:0]          site_count_q;
	logic [CW-1:0]             scan_len;
	logic [CW-1:0]             addr_q;
	logic signed [COORD_W-1:0] qx_q;
	logic signed [COORD_W-1:0] qy_q;

	logic                      v_s1, v_s2, v_s3, v_s4;
	logic [WORD_W-1:0]         word_s1;
	logic signed [DIFF_W-1:0]  dx_s2, dy_s2;
	logic [WORD_W-1:0]         word_s2, word_s3, word_s4;
	logic [DIST_W-1:0]         sqx_s3, sqy_s3;
	logic [DIST_W-1:0]         dist_s4;

	logic signed [2*DIFF_W-1:0] prod_x, prod_y;
	logic signed [COORD_W-1:0]  sx, sy;

	logic [1:0]                seen_q;
	logic [DIST_W-1:0]         d1_q, d2_q;
	logic [WORD_W-1:0]         best_q;

	logic [ROOT_W-1:0]         root1, root2;
	logic                      busy1, busy2;
	logic [EDGE_W-1:0]         edge_d;

	logic                      result_valid_q;
	logic [TAG_W-1:0]          class_q;
	logic signed [COORD_W-1:0] x_q, y_q;
	logic [EDGE_W-1:0]         edge_q;

	logic                      issue;
	logic                      write_ok;

	// Site count register, clamped to the table depth for the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			site_count_q <= '0;
		end else if (site_count_we) begin
			site_count_q <= site_count_wdata;
		end
	end

	always_comb begin
		if (32'(site_count_q) > 32'(MAX_SITES)) begin
			scan_len = CW'(MAX_SITES);
		end else begin
			scan_len = CW'(site_count_q);
		end
	end

	assign issue    = cmd.scan_issue && stat.scan_more;
	assign write_ok = cmd.site_write && (32'(site_index) < 32'(MAX_SITES));

	// Table write port and registered read port
	always_ff @(posedge clk) begin
		if (write_ok) begin
			site_mem[AW'(site_index)] <= {site_class, point_y, point_x};
		end
		word_s1 <= site_mem[addr_q[AW-1:0]];
	end

	// Scan address and query point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cmd.query_start) begin
			addr_q <= '0;
		end else if (issue) begin
			addr_q <= addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.query_start) begin
			qx_q <= point_x;
			qy_q <= point_y;
		end
	end

	// Distance pipe valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign sx     = word_s1[COORD_W-1:0];
	assign sy     = word_s1[2*COORD_W-1:COORD_W];
	assign prod_x = dx_s2 * dx_s2;
	assign prod_y = dy_s2 * dy_s2;

	// Difference, square, sum
	always_ff @(posedge clk) begin
		dx_s2   <= DIFF_W'(qx_q) - DIFF_W'(sx);
		dy_s2   <= DIFF_W'(qy_q) - DIFF_W'(sy);
		word_s2 <= word_s1;
		sqx_s3  <= DIST_W'($unsigned(prod_x));
		sqy_s3  <= DIST_W'($unsigned(prod_y));
		word_s3 <= word_s2;
		dist_s4 <= sqx_s3 + sqy_s3;
		word_s4 <= word_s3;
	end

	// Track nearest and second nearest; a tie keeps the earlier site
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (cmd.query_start) begin
			seen_q <= '0;
		end else if (v_s4 && (seen_q != 2'd2)) begin
			seen_q <= seen_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.query_start) begin
			best_q <= '0;
		end else if (v_s4) begin
			if ((seen_q == 2'd0) || (dist_s4 < d1_q)) begin
				d2_q   <= d1_q;
				d1_q   <= dist_s4;
				best_q <= word_s4;
			end else if ((seen_q == 2'd1) || (dist_s4 < d2_q)) begin
				d2_q <= dist_s4;
			end
		end
	end

	// Square roots of both distances, side by side
	nsvl_sqrt u_sqrt_near (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.root_start),
		.radicand (d1_q),
		.busy     (busy1),
		.root     (root1)
	);

	nsvl_sqrt u_sqrt_second (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.root_start),
		.radicand (d2_q),
		.busy     (busy2),
		.root     (root2)
	);

	// Root difference never exceeds the edge range; saturate with under two sites
	always_comb begin
		if (seen_q != 2'd2) begin
			edge_d = EDGE_MAX;
		end else begin
			edge_d = EDGE_W'(root2 - root1);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			x_q     <= best_q[COORD_W-1:0];
			y_q     <= best_q[2*COORD_W-1:COORD_W];
			class_q <= best_q[WORD_W-1 -: TAG_W];
			edge_q  <= edge_d;
		end
	end

	assign stat.scan_more = (addr_q < scan_len);
	assign stat.pipe_idle = !(v_s1 || v_s2 || v_s3 || v_s4);
	assign stat.root_busy = busy1 || busy2;
	assign stat.out_free  = !result_valid_q || !result_stall;

	assign result_valid  = result_valid_q;
	assign nearest_class = class_q;
	assign nearest_x     = x_q;
	assign nearest_y     = y_q;
	assign edge_distance = edge_q;

endmodule

>>> design/nearest_site_voronoi_lookup_top.sv
// Nearest-site Voronoi lookup. A write item (mode 0) stores one site center and class
// tag; a query item (mode 1) scans sites 0 .. site_count-1 (clamped to
// MAX_SITES), one table read per cycle through a four-stage squared-distance pipe, then
// takes both square roots in parallel one bit per cycle, and returns the nearest site's
// class and center with the F2-F1 edge distance (saturated with fewer than two sites).
// Sites are read through the single table read port. The block takes no new item
// during a query; a finished result waits in the output register without blocking
// the next write or query. Program site_count only while idle, and query only sites
// that were written.
module nearest_site_voronoi_lookup_top #(
	parameter int MAX_SITES = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                site_count_we,
	input  logic [nsvl_pkg::CNT_W-1:0]          site_count_wdata,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic                                mode,
	input  logic [nsvl_pkg::IDX_W-1:0]          site_index,
	input  logic signed [nsvl_pkg::COORD_W-1:0] point_x,
	input  logic signed [nsvl_pkg::COORD_W-1:0] point_y,
	input  logic [nsvl_pkg::TAG_W-1:0]          site_class,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [nsvl_pkg::TAG_W-1:0]          nearest_class,
	output logic signed [nsvl_pkg::COORD_W-1:0] nearest_x,
	output logic signed [nsvl_pkg::COORD_W-1:0] nearest_y,
	output logic [nsvl_pkg::EDGE_W-1:0]         edge_distance
);
	import nsvl_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequence control
	nsvl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.mode       (mode),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	// Site table, distance pipe, roots and result register
	nsvl_datapath #(
		.MAX_SITES (MAX_SITES)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.site_count_we    (site_count_we),
		.site_count_wdata (site_count_wdata),
		.site_index       (site_index),
		.point_x          (point_x),
		.point_y          (point_y),
		.site_class       (site_class),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.nearest_class    (nearest_class),
		.nearest_x        (nearest_x),
		.nearest_y        (nearest_y),
		.edge_distance    (edge_distance)
	);

endmodule

>>> tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import nsvl_pkg::*;

	localparam int SITE_SLOTS    = 64;
	localparam int RANDOM_ITEMS  = 1200;
	localparam int SETTLE_CYCLES = 2 * SITE_SLOTS + 40;
	localparam int HOLD_CYCLES   = 500;
	localparam int CYCLE_LIMIT   = 600000;

	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

	typedef struct packed {
		logic                      mode;
		logic [IDX_W-1:0]          slot;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [TAG_W-1:0]          tag;
	} site_op_t;

	typedef struct packed {
		logic [TAG_W-1:0]          tag;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [EDGE_W-1:0]         edge_dist;
	} answer_t;

	logic                      clk              = 1'b0;
	logic                      arst_n           = 1'b0;
	logic                      site_count_we    = 1'b0;
	logic [CNT_W-1:0]          site_count_wdata = '0;
	logic                      item_valid       = 1'b0;
	logic                      item_stall;
	logic                      mode             = MODE_WRITE;
	logic [IDX_W-1:0]          site_index       = '0;
	logic signed [COORD_W-1:0] point_x          = '0;
	logic signed [COORD_W-1:0] point_y          = '0;
	logic [TAG_W-1:0]          site_class       = '0;
	logic                      result_valid;
	logic                      result_stall     = 1'b0;
	logic [TAG_W-1:0]          nearest_class;
	logic signed [COORD_W-1:0] nearest_x;
	logic signed [COORD_W-1:0] nearest_y;
	logic [EDGE_W-1:0]         edge_distance;

	// Shadow of the site table and the count register
	logic signed [COORD_W-1:0] tbl_x   [SITE_SLOTS];
	logic signed [COORD_W-1:0] tbl_y   [SITE_SLOTS];
	logic [TAG_W-1:0]          tbl_tag [SITE_SLOTS];
	logic [CNT_W-1:0]          count_setting = '0;

	site_op_t site_ops[$];
	answer_t  due_answers[$];
	site_op_t cur_op;

	int ops_queued   = 0;
	int ops_taken    = 0;
	int mismatches   = 0;
	int answers_seen = 0;
	int tx_gap       = 0;
	int tx_calm      = 0;
	int rx_gap       = 0;
	int rx_calm      = 0;
	int rx_hold      = 0;

	nearest_site_voronoi_lookup_top #(
		.MAX_SITES(SITE_SLOTS)
	) i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.site_count_we   (site_count_we),
		.site_count_wdata(site_count_wdata),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.mode            (mode),
		.site_index      (site_index),
		.point_x         (point_x),
		.point_y         (point_y),
		.site_class      (site_class),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.nearest_class   (nearest_class),
		.nearest_x       (nearest_x),
		.nearest_y       (nearest_y),
		.edge_distance   (edge_distance)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Integer square root, one result bit at a time from the top
	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = ROOT_W; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	// Scan the active sites for the nearest and second nearest by squared distance
	function automatic answer_t nearest_site(logic signed [COORD_W-1:0] qx,
			logic signed [COORD_W-1:0] qy);
		answer_t         ans;
		int              scan_n;
		int              seen;
		int              best;
		longint          dx;
		longint          dy;
		longint unsigned dsq;
		longint unsigned d1;
		longint unsigned d2;
		longint unsigned span;
		scan_n = (count_setting > SITE_SLOTS) ? SITE_SLOTS : int'(count_setting);
		seen = 0;
		best = 0;
		d1 = 0;
		d2 = 0;
		for (int k = 0; k < scan_n; k++) begin
			dx = longint'(qx) - longint'(tbl_x[k]);
			dy = longint'(qy) - longint'(tbl_y[k]);
			dsq = dx * dx + dy * dy;
			// strict compare: a tie keeps the earlier site as nearest
			if (seen == 0 || dsq < d1) begin
				d2 = d1;
				d1 = dsq;
				best = k;
			end else if (seen == 1 || dsq < d2) begin
				d2 = dsq;
			end
			if (seen < 2)
				seen++;
		end
		if (seen < 2) begin
			ans.edge_dist = EDGE_MAX;
		end else begin
			span = floor_root(d2) - floor_root(d1);
			ans.edge_dist = (span > EDGE_MAX) ? EDGE_MAX : span[EDGE_W-1:0];
		end
		if (seen == 0) begin
			ans.tag = '0;
			ans.x   = '0;
			ans.y   = '0;
		end else begin
			ans.tag = tbl_tag[best];
			ans.x   = tbl_x[best];
			ans.y   = tbl_y[best];
		end
		return ans;
	endfunction

	// Idle cycles before the next item; now and then a stretch with none
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			calm = $urandom_range(10, 30);
		return $urandom_range(0, 6);
	endfunction

	// Coordinates: extremes, a coarse grid for ties and exact hits, a small cluster, full range
	function automatic logic signed [COORD_W-1:0] pick_coord();
		int v;
		case ($urandom_range(0, 9))
			0: v = int'(COORD_MIN);
			1: v = int'(COORD_MAX);
			2, 3: v = 16 * int'($urandom_range(0, 8)) - 64;
			4, 5: v = int'($urandom_range(0, 127)) - 64;
			default: v = $urandom;
		endcase
		return v[COORD_W-1:0];
	endfunction

	function automatic void add_write(logic [IDX_W-1:0] slot, logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y, logic [TAG_W-1:0] tag);
		site_op_t op;
		op = '{MODE_WRITE, slot, x, y, tag};
		site_ops.insert(site_ops.size(), op);
		ops_queued++;
	endfunction

	// Slot and class ride along on a query with random content
	function automatic void add_query(logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y);
		site_op_t op;
		op = '{MODE_QUERY, IDX_W'($urandom), x, y, TAG_W'($urandom)};
		site_ops.insert(site_ops.size(), op);
		ops_queued++;
	endfunction

	// Wait until every item is taken and answered, then let the block drain
	task automatic settle();
		while (ops_taken != ops_queued || due_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_site_count(int value);
		settle();
		site_count_we    <= 1'b1;
		site_count_wdata <= CNT_W'(value);
		@(posedge clk);
		site_count_we <= 1'b0;
		count_setting = CNT_W'(value);
	endtask

	// Present items from the queue; update the shadow table or predict on each accepted item
	always @(posedge clk) begin : drive_items
		logic offer;
		if (arst_n) begin
			offer = item_valid;
			if (item_valid && !item_stall) begin
				if (cur_op.mode == MODE_WRITE) begin
					tbl_x[cur_op.slot]   = cur_op.x;
					tbl_y[cur_op.slot]   = cur_op.y;
					tbl_tag[cur_op.slot] = cur_op.tag;
				end else begin
					due_answers.insert(due_answers.size(), nearest_site(cur_op.x, cur_op.y));
				end
				ops_taken++;
				offer = 1'b0;
				tx_gap = draw_wait(tx_calm);
			end
			if (!offer && tx_gap > 0) begin
				tx_gap--;
			end else if (!offer && site_ops.size() != 0) begin
				cur_op = site_ops.pop_front();
				mode       <= cur_op.mode;
				site_index <= cur_op.slot;
				point_x    <= cur_op.x;
				point_y    <= cur_op.y;
				site_class <= cur_op.tag;
				offer = 1'b1;
			end
			item_valid <= offer;
		end
	end

	// Compare each accepted answer with the oldest prediction and draw the next stall
	always @(posedge clk) begin : check_answers
		answer_t got;
		answer_t want;
		logic    hold_off;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				got = {nearest_class, nearest_x, nearest_y, edge_distance};
				if (due_answers.size() == 0) begin
					$display("%0t: answer with no query pending: class %0d x %0d y %0d edge %0d",
						$time, got.tag, got.x, got.y, got.edge_dist);
					mismatches++;
				end else begin
					want = due_answers.pop_front();
					if (got !== want) begin
						$display("%0t: expected class %0d x %0d y %0d edge %0d, got class %0d x %0d y %0d edge %0d",
							$time, want.tag, want.x, want.y, want.edge_dist,
							got.tag, got.x, got.y, got.edge_dist);
						mismatches++;
					end
				end
				answers_seen++;
				// hold off for a long stretch now and then so the block backs up
				if (answers_seen % 200 == 100)
					rx_hold = HOLD_CYCLES;
				rx_gap = draw_wait(rx_calm);
			end
			hold_off = 1'b0;
			if (rx_hold > 0) begin
				rx_hold--;
				hold_off = 1'b1;
			end else if (rx_gap > 0) begin
				rx_gap--;
				hold_off = 1'b1;
			end
			result_stall <= hold_off;
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin : run_phases
		int random_left;
		int burst;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: class 0 at the origin, saturated edge
		set_site_count(0);
		add_query(COORD_MAX, COORD_MIN);
		add_query(COORD_MIN, COORD_MAX);
		add_query('0, '0);
		add_write(0, COORD_MIN, COORD_MIN, 4'hF);
		add_write(1, COORD_MAX, COORD_MAX, 4'h0);
		add_write(2, -20'sd16, '0, 4'h5);
		add_write(3, 20'sd16, '0, 4'hA);

		// Single site: saturated edge, farthest possible point
		set_site_count(1);
		add_query(COORD_MAX, COORD_MAX);
		add_query(COORD_MIN, COORD_MIN);

		// Equal distances to sites 2 and 3, exact hit, opposite corners
		set_site_count(4);
		add_query('0, 20'sd100);
		add_query('0, COORD_MIN);
		add_query(COORD_MAX, COORD_MAX);
		add_query(COORD_MIN, COORD_MAX);
		add_query(COORD_MIN, COORD_MIN);

		// Fill the rest of the table so any count scans written slots only
		settle();
		for (int k = 4; k < SITE_SLOTS; k++)
			add_write(IDX_W'(k), pick_coord(), pick_coord(), TAG_W'($urandom));

		// Count above the table size scans the whole table
		set_site_count(127);
		add_query(COORD_MAX, COORD_MIN);
		add_query(pick_coord(), pick_coord());
		add_query(pick_coord(), pick_coord());

		// Random phases, each with its own count
		random_left = RANDOM_ITEMS;
		while (random_left > 0) begin
			case ($urandom_range(0, 7))
				0: set_site_count(0);
				1: set_site_count(1);
				2: set_site_count(2);
				3: set_site_count(SITE_SLOTS);
				4: set_site_count($urandom_range(SITE_SLOTS + 1, 127));
				5: set_site_count($urandom_range(21, SITE_SLOTS));
				default: set_site_count($urandom_range(3, 20));
			endcase
			burst = $urandom_range(40, 160);
			if (burst > random_left)
				burst = random_left;
			for (int k = 0; k < burst; k++) begin
				if ($urandom_range(0, 99) < 35)
					add_write(IDX_W'($urandom), pick_coord(), pick_coord(), TAG_W'($urandom));
				else
					add_query(pick_coord(), pick_coord());
			end
			random_left -= burst;
		end

		settle();
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
